### hw/rtl/area_average_image_resample_assert.svh
`ifndef AREA_AVERAGE_IMAGE_RESAMPLE_ASSERT_SVH
`define AREA_AVERAGE_IMAGE_RESAMPLE_ASSERT_SVH

// Both macros sample on the rising edge of clk and are disabled during reset.
`define AARS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

`define AARS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### hw/rtl/aars_pkg.sv
package aars_pkg;

  localparam int CFG_W      = 9;
  localparam int COORD_W    = 8;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 9'd256;
  localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 9'd256;
  localparam logic [CFG_W-1:0] DST_SIZE_RST   = 9'd64;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_SIZE   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    DIV_X0    = 3'd0,
    DIV_X1    = 3'd1,
    DIV_Y0    = 3'd2,
    DIV_Y1    = 3'd3,
    DIV_RED   = 3'd4,
    DIV_GREEN = 3'd5,
    DIV_BLUE  = 3'd6
  } div_sel_t;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [CHAN_W-1:0]  src_red;
    logic [CHAN_W-1:0]  src_green;
    logic [CHAN_W-1:0]  src_blue;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] avg_red;
    logic [CHAN_W-1:0] avg_green;
    logic [CHAN_W-1:0] avg_blue;
  } out_item_t;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    div_sel_t div_sel;
    logic     store;
    logic     walk_init;
    logic     walk_step;
    logic     emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic empty;
    logic last;
  } dp_status_t;

endpackage

### hw/rtl/aars_ram.sv
module aars_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/aars_div.sv
module aars_div #(
  parameter int DW = 25,
  parameter int VW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   q_r;
  logic [VW:0]     rem_r;
  logic [VW-1:0]   div_r;
  logic [CNTW-1:0] cnt_r;
  logic            run_r;
  logic            done_r;
  logic [VW:0]     rem_sh;
  logic            ge;

  assign rem_sh = {rem_r[VW-1:0], q_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(DW);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, div_r}) : rem_sh;
      q_r   <= {q_r[DW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### hw/rtl/aars_ctrl.sv
module aars_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   item_cmd,
  input  aars_pkg::dp_status_t   status,
  output aars_pkg::ctrl_cmd_t    cmd,
  output logic                   busy
);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_DIV_GO    = 7'b0000010,
    ST_DIV_WAIT  = 7'b0000100,
    ST_WALK_INIT = 7'b0001000,
    ST_WALK      = 7'b0010000,
    ST_DRAIN     = 7'b0100000,
    ST_DONE      = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  aars_pkg::div_sel_t  sel_r, sel_nxt;

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    cmd         = '0;
    cmd.div_sel = sel_r;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = start;
        if (start && item_cmd == aars_pkg::CMD_READ) begin
          state_nxt = ST_DIV_GO;
          sel_nxt   = aars_pkg::DIV_X0;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.store = 1'b1;
          state_nxt = ST_DIV_GO;
          case (sel_r)
            aars_pkg::DIV_X0:    sel_nxt = aars_pkg::DIV_X1;
            aars_pkg::DIV_X1:    sel_nxt = aars_pkg::DIV_Y0;
            aars_pkg::DIV_Y0:    sel_nxt = aars_pkg::DIV_Y1;
            aars_pkg::DIV_Y1:    state_nxt = ST_WALK_INIT;
            aars_pkg::DIV_RED:   sel_nxt = aars_pkg::DIV_GREEN;
            aars_pkg::DIV_GREEN: sel_nxt = aars_pkg::DIV_BLUE;
            aars_pkg::DIV_BLUE:  state_nxt = ST_DONE;
            default:             state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WALK_INIT: begin
        cmd.walk_init = 1'b1;
        if (status.empty) begin
          sel_nxt   = aars_pkg::DIV_RED;
          state_nxt = ST_DIV_GO;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        sel_nxt   = aars_pkg::DIV_RED;
        state_nxt = ST_DIV_GO;
      end
      ST_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= aars_pkg::DIV_X0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

### hw/rtl/aars_dp.sv
module aars_dp #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_SIZE   = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [aars_pkg::CFG_W-1:0]    src_width,
  input  logic [aars_pkg::CFG_W-1:0]    src_height,
  input  logic [aars_pkg::CFG_W-1:0]    dst_size,
  input  aars_pkg::in_item_t            in_item,
  input  aars_pkg::ctrl_cmd_t           cmd,
  output aars_pkg::dp_status_t          status,
  output logic                          out_valid,
  output aars_pkg::out_item_t           out_item
);

  localparam int XA    = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
  localparam int YA    = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
  localparam int AW    = XA + YA;
  localparam int DEPTH = 1 << AW;
  localparam int WVW   = $clog2(MAX_SRC_WIDTH + 1);
  localparam int HVW   = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int SZW   = $clog2(MAX_DST_SIZE + 1);
  localparam int LW    = (WVW > HVW) ? WVW : HVW;
  localparam int MDW   = aars_pkg::COORD_W + 1;
  localparam int NW    = MDW + LW;
  localparam int CW    = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT + 1);
  localparam int SW    = aars_pkg::CHAN_W + CW;
  localparam int DW    = (NW > SW) ? NW : SW;
  localparam int VW    = (SZW > CW) ? SZW : CW;
  localparam int CH    = aars_pkg::CHAN_W;

  logic [WVW-1:0] w_eff;
  logic [HVW-1:0] h_eff;
  logic [SZW-1:0] size_eff;

  always_comb begin
    if (src_width == '0) begin
      w_eff = WVW'(1);
    end else if (32'(src_width) > MAX_SRC_WIDTH) begin
      w_eff = WVW'(MAX_SRC_WIDTH);
    end else begin
      w_eff = WVW'(src_width);
    end
    if (src_height == '0) begin
      h_eff = HVW'(1);
    end else if (32'(src_height) > MAX_SRC_HEIGHT) begin
      h_eff = HVW'(MAX_SRC_HEIGHT);
    end else begin
      h_eff = HVW'(src_height);
    end
    if (dst_size == '0) begin
      size_eff = SZW'(1);
    end else if (32'(dst_size) > MAX_DST_SIZE) begin
      size_eff = SZW'(MAX_DST_SIZE);
    end else begin
      size_eff = SZW'(dst_size);
    end
  end

  // Source pixel writes go straight into the image memory.
  logic [31:0]                   wx32, wy32;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [aars_pkg::PIX_W-1:0]    ram_wdata, ram_rdata;

  assign wx32      = 32'(in_item.coord_x);
  assign wy32      = 32'(in_item.coord_y);
  assign ram_we    = cmd.accept && (in_item.cmd == aars_pkg::CMD_WRITE) &&
                     (wx32 < MAX_SRC_WIDTH) && (wy32 < MAX_SRC_HEIGHT);
  assign ram_waddr = {wy32[YA-1:0], wx32[XA-1:0]};
  assign ram_wdata = {in_item.src_red, in_item.src_green, in_item.src_blue};

  logic [aars_pkg::COORD_W-1:0] cx_r, cy_r;
  logic [WVW-1:0] x0_r, x1_r, sx_r;
  logic [HVW-1:0] y0_r, y1_r, sy_r;
  logic [SW-1:0]  sum_red_r, sum_green_r, sum_blue_r;
  logic [CW-1:0]  cnt_r;
  logic           rd_vld_r;
  logic           out_valid_r;
  logic [CH-1:0]  avg_red_r, avg_green_r, avg_blue_r;

  assign ram_raddr = {sy_r[YA-1:0], sx_r[XA-1:0]};

  aars_ram #(
    .WIDTH (aars_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Operand selection for the shared divider.
  logic [MDW-1:0] mul_d;
  logic [LW-1:0]  mul_len;
  logic [NW-1:0]  prod;
  logic [CW-1:0]  cnt_div;
  logic [DW-1:0]  dividend;
  logic [VW-1:0]  divisor;
  logic [DW-1:0]  quo;
  logic           div_done;

  assign cnt_div = (cnt_r == '0) ? CW'(1) : cnt_r;
  assign prod    = NW'(mul_d) * NW'(mul_len);

  always_comb begin
    mul_d    = MDW'(cx_r);
    mul_len  = LW'(w_eff);
    dividend = DW'(prod);
    divisor  = VW'(size_eff);
    case (cmd.div_sel)
      aars_pkg::DIV_X0: begin
        mul_d   = MDW'(cx_r);
        mul_len = LW'(w_eff);
      end
      aars_pkg::DIV_X1: begin
        mul_d   = MDW'(cx_r) + MDW'(1);
        mul_len = LW'(w_eff);
      end
      aars_pkg::DIV_Y0: begin
        mul_d   = MDW'(cy_r);
        mul_len = LW'(h_eff);
      end
      aars_pkg::DIV_Y1: begin
        mul_d   = MDW'(cy_r) + MDW'(1);
        mul_len = LW'(h_eff);
      end
      aars_pkg::DIV_RED: begin
        dividend = DW'(sum_red_r);
        divisor  = VW'(cnt_div);
      end
      aars_pkg::DIV_GREEN: begin
        dividend = DW'(sum_green_r);
        divisor  = VW'(cnt_div);
      end
      aars_pkg::DIV_BLUE: begin
        dividend = DW'(sum_blue_r);
        divisor  = VW'(cnt_div);
      end
      default: begin
        dividend = '0;
        divisor  = VW'(1);
      end
    endcase
  end

  aars_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo)
  );

  // Box bounds, clipped to the image. The end is at least one past the start unless clipped at the image edge.
  logic [DW-1:0] w_dw, h_dw, x_lo1, y_lo1, x_end, y_end;
  logic [DW-1:0] x0_val, y0_val, x1_val, y1_val;

  assign w_dw   = DW'(w_eff);
  assign h_dw   = DW'(h_eff);
  assign x0_val = (quo > w_dw) ? w_dw : quo;
  assign y0_val = (quo > h_dw) ? h_dw : quo;
  assign x_lo1  = DW'(x0_r) + DW'(1);
  assign y_lo1  = DW'(y0_r) + DW'(1);
  assign x_end  = (quo < x_lo1) ? x_lo1 : quo;
  assign y_end  = (quo < y_lo1) ? y_lo1 : quo;
  assign x1_val = (x_end > w_dw) ? w_dw : x_end;
  assign y1_val = (y_end > h_dw) ? h_dw : y_end;

  logic [WVW-1:0] sx_inc;
  logic [HVW-1:0] sy_inc;

  assign sx_inc = sx_r + WVW'(1);
  assign sy_inc = sy_r + HVW'(1);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cx_r <= in_item.coord_x;
      cy_r <= in_item.coord_y;
    end
    if (cmd.store) begin
      case (cmd.div_sel)
        aars_pkg::DIV_X0:    x0_r <= WVW'(x0_val);
        aars_pkg::DIV_X1:    x1_r <= WVW'(x1_val);
        aars_pkg::DIV_Y0:    y0_r <= HVW'(y0_val);
        aars_pkg::DIV_Y1:    y1_r <= HVW'(y1_val);
        aars_pkg::DIV_RED:   avg_red_r <= quo[CH-1:0];
        aars_pkg::DIV_GREEN: avg_green_r <= quo[CH-1:0];
        aars_pkg::DIV_BLUE:  avg_blue_r <= quo[CH-1:0];
        default:             avg_blue_r <= avg_blue_r;
      endcase
    end
    if (cmd.walk_init) begin
      sx_r        <= x0_r;
      sy_r        <= y0_r;
      sum_red_r   <= '0;
      sum_green_r <= '0;
      sum_blue_r  <= '0;
      cnt_r       <= '0;
    end else begin
      if (cmd.walk_step) begin
        if (sx_inc == x1_r) begin
          sx_r <= x0_r;
          sy_r <= sy_inc;
        end else begin
          sx_r <= sx_inc;
        end
      end
      if (rd_vld_r) begin
        sum_red_r   <= sum_red_r + SW'(ram_rdata[3*CH-1:2*CH]);
        sum_green_r <= sum_green_r + SW'(ram_rdata[2*CH-1:CH]);
        sum_blue_r  <= sum_blue_r + SW'(ram_rdata[CH-1:0]);
        cnt_r       <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= cmd.walk_step;
      out_valid_r <= cmd.emit;
    end
  end

  assign status.div_done = div_done;
  assign status.empty    = (x0_r >= x1_r) || (y0_r >= y1_r);
  assign status.last     = (sx_inc == x1_r) && (sy_inc == y1_r);

  assign out_valid          = out_valid_r;
  assign out_item.avg_red   = avg_red_r;
  assign out_item.avg_green = avg_green_r;
  assign out_item.avg_blue  = avg_blue_r;

endmodule

### hw/rtl/area_average_image_resample.sv
// Area-average image downscaler with an on-chip RGB888 source image memory.
// Configuration goes through the APB port: src_width at 0x0, src_height at
// 0x4 and dst_size at 0x8, all 9 bits; the user must write them only while
// busy is low, as the block does not enforce it. A transaction on the input
// channel is taken when start is high and busy is low. A write transaction
// stores one source pixel and leaves busy low, so writes can stream one per cycle.
// A read transaction raises busy and computes one destination pixel. The
// serial restoring divider runs seven divisions in turn (DW is 25 at the
// default sizes), and the box walk does one memory read per source pixel,
// skipped for an empty box.
// The result appears on out_item for exactly one cycle with out_valid high,
// in the cycle in which busy has returned low. The receiver cannot stall.
// Reset restores the register defaults (256, 256, 64) and idles the block;
// the image memory is not cleared and must be loaded before it is read.
module area_average_image_resample #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_SIZE   = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aars_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [aars_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [aars_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                start,
  input  aars_pkg::in_item_t                  in_item,
  output logic                                busy,
  output logic                                out_valid,
  output aars_pkg::out_item_t                 out_item
);

  logic [aars_pkg::CFG_W-1:0] src_width_r, src_height_r, dst_size_r;
  logic                       reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= aars_pkg::SRC_WIDTH_RST;
      src_height_r <= aars_pkg::SRC_HEIGHT_RST;
      dst_size_r   <= aars_pkg::DST_SIZE_RST;
    end else if (reg_wr) begin
      case (aars_pkg::reg_idx_t'(paddr[3:2]))
        aars_pkg::REG_SRC_WIDTH:  src_width_r  <= pwdata[aars_pkg::CFG_W-1:0];
        aars_pkg::REG_SRC_HEIGHT: src_height_r <= pwdata[aars_pkg::CFG_W-1:0];
        aars_pkg::REG_DST_SIZE:   dst_size_r   <= pwdata[aars_pkg::CFG_W-1:0];
        default:                  dst_size_r   <= dst_size_r;
      endcase
    end
  end

  always_comb begin
    case (aars_pkg::reg_idx_t'(paddr[3:2]))
      aars_pkg::REG_SRC_WIDTH:  prdata = aars_pkg::APB_DATA_W'(src_width_r);
      aars_pkg::REG_SRC_HEIGHT: prdata = aars_pkg::APB_DATA_W'(src_height_r);
      aars_pkg::REG_DST_SIZE:   prdata = aars_pkg::APB_DATA_W'(dst_size_r);
      default:                  prdata = '0;
    endcase
  end

  aars_pkg::ctrl_cmd_t  cmd;
  aars_pkg::dp_status_t status;

  aars_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .item_cmd (in_item.cmd),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  aars_dp #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .MAX_DST_SIZE   (MAX_DST_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .src_width  (src_width_r),
    .src_height (src_height_r),
    .dst_size   (dst_size_r),
    .in_item    (in_item),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule

### hw/rtl/aars_chk.sv
`include "area_average_image_resample_assert.svh"

module aars_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input aars_pkg::in_item_t in_item,
  input logic               out_valid
);

  logic rd_take, wr_take;

  assign rd_take = start && !busy && (in_item.cmd == aars_pkg::CMD_READ);
  assign wr_take = start && !busy && (in_item.cmd == aars_pkg::CMD_WRITE);

  `AARS_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `AARS_ASSERT_NEXT(a_read_busy, rd_take, busy)
  `AARS_ASSERT_NEXT(a_write_quiet, wr_take, !busy && !out_valid)
  `AARS_ASSERT_SAME(a_result_idle, out_valid, !busy)
  `AARS_ASSERT_SAME(a_busy_cause, $rose(busy), $past(rd_take))

endmodule

bind area_average_image_resample aars_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid)
);
